// ===== rtl/core/lgts_pkg.sv =====
// Shared constants for the LDA Gibbs topic sampler: default sizes, field
// widths, configuration register indexes and their reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lgts_pkg;

    // Default sizes of the count tables and the token store.
    localparam int DEF_MAX_TOPICS  = 64;
    localparam int DEF_MAX_WORDS   = 4096;
    localparam int DEF_MAX_DOCS    = 1024;
    localparam int DEF_MAX_TOKENS  = 65536;
    localparam int DEF_COUNT_WIDTH = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOPICS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOCABULARY = 3'd3;

    localparam logic [23:0] ALPHA_RESET      = 24'd65536;
    localparam logic [23:0] BETA_RESET       = 24'd655;
    localparam logic [6:0]  TOPICS_RESET     = 7'd64;
    localparam logic [12:0] VOCABULARY_RESET = 13'd4096;

    // Action codes of an input item.
    localparam logic ACT_ASSIGN   = 1'b0;
    localparam logic ACT_RESAMPLE = 1'b1;

    // Weight arithmetic.
    localparam int          WEIGHT_W   = 32;
    localparam logic [31:0] WEIGHT_SAT = 32'hFFFF_FFFF;
    localparam int          MUL_CHUNK  = 16;

endpackage

`default_nettype wire

// ===== rtl/core/lda_gibbs_topic_sampler_unit.sv =====
// Top level of the LDA collapsed Gibbs topic sampler: count memories, token
// store, weight buffer and the sequencer around one shared divider.
// Depends on lgts_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One item is one word token. An assign item records the given topic for the
// token slot and bumps the word-topic, document-topic and topic-total counts.
// A resample item removes the slot's old topic from the counts, weighs each
// topic in use by (nw+beta)/(nt+V*beta)*(nd+alpha) in Q8.24, draws the first
// topic whose running sum reaches random_word/2^32 of the total, and adds
// that topic back. The weight of one topic goes through a single restoring
// divider, one quotient bit a cycle, then a 32x16 multiplier one chunk at a
// time (three chunks at the defaults); a zero denominator or a saturating
// ratio skips both. The draw then walks the weight buffer one topic at a time.
// The block takes one item at a time; its result waits in an output
// register, and the next item is taken while that result is still
// unclaimed. After reset a clearing pass zeroes the count memories, one
// entry a cycle; no item is taken meanwhile, but configuration writes are.
// Word, document and slot numbers beyond the table sizes wrap.
module lda_gibbs_topic_sampler_unit
    import lgts_pkg::*;
#(
    parameter int MAX_TOPICS  = DEF_MAX_TOPICS,
    parameter int MAX_WORDS   = DEF_MAX_WORDS,
    parameter int MAX_DOCS    = DEF_MAX_DOCS,
    parameter int MAX_TOKENS  = DEF_MAX_TOKENS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic [11:0]           word_id,
    input  wire logic [9:0]            doc_id,
    input  wire logic [15:0]           token_index,
    input  wire logic [5:0]            initial_topic,
    input  wire logic [31:0]           random_word,
    input  wire logic                  end_of_sweep,
    // result items
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [5:0]                 new_topic,
    output logic                       sweep_end
);

    localparam int TW     = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
    localparam int NTW    = $clog2(MAX_TOPICS + 1);
    localparam int WBITS  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int DBITS  = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int SBITS  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int WT_AW  = WBITS + TW;
    localparam int DT_AW  = DBITS + TW;
    localparam int WT_DEPTH = MAX_WORDS * (2 ** TW);
    localparam int DT_DEPTH = MAX_DOCS * (2 ** TW);
    localparam int CLR_DEPTH = (WT_DEPTH > DT_DEPTH) ? WT_DEPTH : DT_DEPTH;
    localparam int CLRW   = $clog2(CLR_DEPTH);
    localparam int CW     = COUNT_WIDTH;
    localparam int VBW    = 37;
    localparam int NUMW   = CW + 17;
    localparam int DENW   = ((CW + 16 > VBW) ? CW + 16 : VBW) + 1;
    localparam int MULW   = CW + 17;
    localparam int DVW    = DENW + 32;
    localparam int MCH    = (MULW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MPW    = MCH * MUL_CHUNK;
    localparam int PRW    = WEIGHT_W + MPW;
    localparam int PPW    = WEIGHT_W + MUL_CHUNK;
    localparam int KW     = (MCH > 1) ? $clog2(MCH) : 1;
    localparam int TOTW   = WEIGHT_W + TW;

    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_REDUCE, S_DISPATCH, S_TOK_RD, S_DEC_RD, S_DEC_WR,
        S_W_RD, S_W_SETUP, S_W_CHK, S_W_DIV, S_W_MULP, S_W_MULA, S_W_SAT,
        S_W_ACC, S_THR_MUL, S_THR_ADD, S_SEL_RD, S_SEL_CMP, S_INC_RD, S_INC_WR
    } state_t;

    state_t state_reg;

    // configuration
    logic [23:0] alpha_reg, beta_reg;
    logic [6:0]  topics_reg;
    logic [12:0] vocab_reg;

    // item fields
    logic        action_reg;
    logic [11:0] word_reg;
    logic [9:0]  doc_reg;
    logic [15:0] slot_reg;
    logic [5:0]  init_reg;
    logic [31:0] rnd_reg;
    logic        eos_reg;

    // sequencer datapath
    logic [CLRW-1:0]  clr_reg;
    logic [NTW-1:0]   j_reg;
    logic [TW-1:0]    old_reg, chosen_reg;
    logic [VBW-1:0]   vbeta_reg;
    logic [NUMW-1:0]  num_reg;
    logic [DENW-1:0]  den_reg;
    logic [MPW-1:0]   mul_reg;
    logic [DVW-1:0]   rem_reg, dsh_reg;
    logic [4:0]       bit_reg;
    logic [31:0]      ratio_reg;
    logic [KW-1:0]    k_reg;
    logic [PPW-1:0]   pp_reg;
    logic [PRW-1:0]   acc_reg;
    logic [31:0]      w_reg;
    logic [TOTW-1:0]  total_reg, thr_reg, run_reg;
    logic [TOTW-1:0]  m1_reg;
    logic [63:0]      m2_reg;

    logic        out_valid_reg;
    logic [5:0]  new_topic_reg;
    logic        sweep_end_reg;

    // memories and their ports
    logic [CW-1:0] wt_mem [WT_DEPTH];
    logic [CW-1:0] dt_mem [DT_DEPTH];
    logic [CW-1:0] tt_mem [MAX_TOPICS];
    logic [TW-1:0] tok_mem [MAX_TOKENS];
    logic [31:0]   wb_mem [MAX_TOPICS];

    logic [CW-1:0] wt_rd, dt_rd, tt_rd;
    logic [TW-1:0] tok_rd;
    logic [31:0]   wb_rd;

    logic [TW-1:0]    topic_sel;
    logic [WBITS-1:0] word_a;
    logic [DBITS-1:0] doc_a;
    logic [SBITS-1:0] slot_a;
    logic [WT_AW-1:0] wt_addr;
    logic [DT_AW-1:0] dt_addr;
    logic             cnt_wr, cnt_up;
    logic             clearing;
    logic             out_free;
    logic [NTW-1:0]   nt_use;
    logic [12:0]      v_use;
    logic [TOTW-1:0]  run_sum;

    // Number of topics in use: zero acts as one, beyond the table as its size.
    always_comb
    begin
        if (topics_reg == 7'd0)
            nt_use = NTW'(1);
        else if (32'(topics_reg) > MAX_TOPICS)
            nt_use = NTW'(MAX_TOPICS);
        else
            nt_use = NTW'(topics_reg);
        v_use = (vocab_reg == 13'd0) ? 13'd1 : vocab_reg;
    end

    assign word_a   = WBITS'(word_reg);
    assign doc_a    = DBITS'(doc_reg);
    assign slot_a   = SBITS'(slot_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign clearing = (state_reg == S_CLEAR);
    assign run_sum  = run_reg + TOTW'(wb_rd);

    always_comb
    begin
        case (state_reg)
            S_DEC_RD:           topic_sel = tok_rd;
            S_DEC_WR:           topic_sel = old_reg;
            S_INC_RD, S_INC_WR: topic_sel = chosen_reg;
            default:            topic_sel = j_reg[TW-1:0];
        endcase
        wt_addr = {word_a, topic_sel};
        dt_addr = {doc_a, topic_sel};
        cnt_wr  = (state_reg == S_DEC_WR) || ((state_reg == S_INC_WR) && out_free);
        cnt_up  = (state_reg == S_INC_WR);
    end

    // Count memories: one read and one write address each, read data
    // registered. The clearing pass writes zero through the same port.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            if (32'(clr_reg) < WT_DEPTH)
                wt_mem[clr_reg[WT_AW-1:0]] <= '0;
            if (32'(clr_reg) < DT_DEPTH)
                dt_mem[clr_reg[DT_AW-1:0]] <= '0;
            if (32'(clr_reg) < MAX_TOPICS)
                tt_mem[clr_reg[TW-1:0]] <= '0;
        end
        else if (cnt_wr)
        begin
            if (cnt_up)
            begin
                wt_mem[wt_addr]   <= (wt_rd == CNT_MAX) ? wt_rd : wt_rd + 1'b1;
                dt_mem[dt_addr]   <= (dt_rd == CNT_MAX) ? dt_rd : dt_rd + 1'b1;
                tt_mem[topic_sel] <= (tt_rd == CNT_MAX) ? tt_rd : tt_rd + 1'b1;
            end
            else
            begin
                wt_mem[wt_addr]   <= (wt_rd == '0) ? wt_rd : wt_rd - 1'b1;
                dt_mem[dt_addr]   <= (dt_rd == '0) ? dt_rd : dt_rd - 1'b1;
                tt_mem[topic_sel] <= (tt_rd == '0) ? tt_rd : tt_rd - 1'b1;
            end
        end
        wt_rd <= wt_mem[wt_addr];
        dt_rd <= dt_mem[dt_addr];
        tt_rd <= tt_mem[topic_sel];
    end

    // Token store and weight buffer.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_INC_WR) && out_free)
            tok_mem[slot_a] <= chosen_reg;
        if (state_reg == S_W_ACC)
            wb_mem[j_reg[TW-1:0]] <= w_reg;
        tok_rd <= tok_mem[slot_a];
        wb_rd  <= wb_mem[j_reg[TW-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ALPHA_RESET;
            beta_reg   <= BETA_RESET;
            topics_reg <= TOPICS_RESET;
            vocab_reg  <= VOCABULARY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHA:      alpha_reg  <= cfg_data;
                REG_BETA:       beta_reg   <= cfg_data;
                REG_TOPICS:     topics_reg <= cfg_data[6:0];
                REG_VOCABULARY: vocab_reg  <= cfg_data[12:0];
                default:        ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A result claimed in the same cycle as a new one is registered
            // is replaced by the new one in the final update step below.
            if (out_valid_reg && out_ready && !((state_reg == S_INC_WR) && out_free))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == CLR_DEPTH - 1)
                        state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        action_reg <= action;
                        word_reg   <= word_id;
                        doc_reg    <= doc_id;
                        slot_reg   <= token_index;
                        init_reg   <= initial_topic;
                        rnd_reg    <= random_word;
                        eos_reg    <= end_of_sweep;
                        state_reg  <= S_REDUCE;
                    end
                end

                // Wrap addresses beyond the table sizes, one subtraction a cycle.
                S_REDUCE:
                begin
                    if (32'(word_reg) >= MAX_WORDS)
                        word_reg <= 12'(32'(word_reg) - MAX_WORDS);
                    if (32'(doc_reg) >= MAX_DOCS)
                        doc_reg <= 10'(32'(doc_reg) - MAX_DOCS);
                    if (32'(slot_reg) >= MAX_TOKENS)
                        slot_reg <= 16'(32'(slot_reg) - MAX_TOKENS);
                    if (32'(word_reg) < MAX_WORDS && 32'(doc_reg) < MAX_DOCS &&
                        32'(slot_reg) < MAX_TOKENS)
                        state_reg <= S_DISPATCH;
                end

                S_DISPATCH:
                begin
                    vbeta_reg <= VBW'(v_use) * VBW'(beta_reg);
                    if (action_reg == ACT_ASSIGN)
                    begin
                        if (32'(init_reg) >= 32'(nt_use))
                            chosen_reg <= TW'(nt_use - 1'b1);
                        else
                            chosen_reg <= TW'(init_reg);
                        state_reg <= S_INC_RD;
                    end
                    else
                        state_reg <= S_TOK_RD;
                end

                S_TOK_RD: state_reg <= S_DEC_RD;

                S_DEC_RD:
                begin
                    old_reg   <= tok_rd;
                    state_reg <= S_DEC_WR;
                end

                S_DEC_WR:
                begin
                    j_reg     <= '0;
                    total_reg <= '0;
                    state_reg <= S_W_RD;
                end

                S_W_RD: state_reg <= S_W_SETUP;

                S_W_SETUP:
                begin
                    num_reg   <= (NUMW'(wt_rd) << 16) + NUMW'(beta_reg);
                    den_reg   <= (DENW'(tt_rd) << 16) + DENW'(vbeta_reg);
                    mul_reg   <= (MPW'(dt_rd) << 16) + MPW'(alpha_reg);
                    state_reg <= S_W_CHK;
                end

                // Zero denominator weighs zero; an integer part of 256 or
                // more saturates; otherwise start the divider.
                S_W_CHK:
                begin
                    if (den_reg == '0)
                    begin
                        w_reg     <= '0;
                        state_reg <= S_W_ACC;
                    end
                    else if (DVW'(num_reg) >= (DVW'(den_reg) << 8))
                    begin
                        w_reg     <= WEIGHT_SAT;
                        state_reg <= S_W_ACC;
                    end
                    else
                    begin
                        rem_reg   <= DVW'(num_reg) << 24;
                        dsh_reg   <= DVW'(den_reg) << 31;
                        bit_reg   <= '0;
                        ratio_reg <= '0;
                        state_reg <= S_W_DIV;
                    end
                end

                S_W_DIV:
                begin
                    if (rem_reg >= dsh_reg)
                    begin
                        rem_reg   <= rem_reg - dsh_reg;
                        ratio_reg <= {ratio_reg[30:0], 1'b1};
                    end
                    else
                        ratio_reg <= {ratio_reg[30:0], 1'b0};
                    dsh_reg <= dsh_reg >> 1;
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 5'd31)
                    begin
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_W_MULP;
                    end
                end

                S_W_MULP:
                begin
                    pp_reg    <= PPW'(ratio_reg) * PPW'(mul_reg[MUL_CHUNK*k_reg +: MUL_CHUNK]);
                    state_reg <= S_W_MULA;
                end

                S_W_MULA:
                begin
                    acc_reg <= acc_reg + (PRW'(pp_reg) << (MUL_CHUNK * k_reg));
                    k_reg   <= k_reg + 1'b1;
                    if (32'(k_reg) == MCH - 1)
                        state_reg <= S_W_SAT;
                    else
                        state_reg <= S_W_MULP;
                end

                S_W_SAT:
                begin
                    if (|acc_reg[PRW-1:WEIGHT_W+16])
                        w_reg <= WEIGHT_SAT;
                    else
                        w_reg <= acc_reg[WEIGHT_W+15:16];
                    state_reg <= S_W_ACC;
                end

                S_W_ACC:
                begin
                    total_reg <= total_reg + TOTW'(w_reg);
                    if (j_reg + 1'b1 == nt_use)
                        state_reg <= S_THR_MUL;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_W_RD;
                    end
                end

                // Threshold = floor(random * total / 2^32), in two products.
                S_THR_MUL:
                begin
                    m1_reg    <= TOTW'(rnd_reg) * TOTW'(total_reg[TOTW-1:32]);
                    m2_reg    <= 64'(rnd_reg) * 64'(total_reg[31:0]);
                    state_reg <= S_THR_ADD;
                end

                S_THR_ADD:
                begin
                    thr_reg   <= m1_reg + TOTW'(m2_reg[63:32]);
                    j_reg     <= '0;
                    run_reg   <= '0;
                    state_reg <= S_SEL_RD;
                end

                S_SEL_RD: state_reg <= S_SEL_CMP;

                S_SEL_CMP:
                begin
                    run_reg <= run_sum;
                    if (run_sum >= thr_reg)
                    begin
                        chosen_reg <= j_reg[TW-1:0];
                        state_reg  <= S_INC_RD;
                    end
                    else if (j_reg + 1'b1 == nt_use)
                    begin
                        chosen_reg <= TW'(nt_use - 1'b1);
                        state_reg  <= S_INC_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SEL_RD;
                    end
                end

                S_INC_RD: state_reg <= S_INC_WR;

                S_INC_WR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        new_topic_reg <= 6'(chosen_reg);
                        sweep_end_reg <= eos_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign new_topic = new_topic_reg;
    assign sweep_end = sweep_end_reg;

    // A result only appears at the end of the count update.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_INC_WR)
        else $error("result raised outside the final update step");

    // The draw never looks past the topics in use.
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL_CMP || state_reg == S_W_ACC) |-> j_reg < nt_use)
        else $error("topic index beyond topics in use");

    // No item is taken while the clearing pass runs.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("item accepted during clearing pass");

    // The divider runs 32 steps and then hands over to the multiplier.
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W_DIV && bit_reg == 5'd31) |=> state_reg == S_W_MULP)
        else $error("divider step count wrong");

endmodule

`default_nettype wire
